// ===== hdl/sha1bc_pkg.sv =====
// sha1bc_pkg: shared types, constants and round helpers for the SHA-1 block
// compression engine. Used by every module under hdl/; depends on nothing.

package sha1bc_pkg;

  localparam int unsigned WORD_W         = 32;
  localparam int unsigned COUNT_W        = 64;
  localparam int unsigned NUM_CHAIN      = 5;
  localparam int unsigned NUM_WORDS      = 16;
  localparam int unsigned NUM_ROUNDS     = 80;
  localparam int unsigned ROUND_W        = 7;
  localparam int unsigned WORD_POS_W     = $clog2(NUM_WORDS);
  localparam int unsigned BLOCK_BYTES    = 64;
  localparam int unsigned FIFO_DEPTH_DEF = 4;
  localparam int unsigned CFG_IDX_W      = 3;

  // Schedule window taps: slot 0 holds W[t-16], the others W[t-14], W[t-8], W[t-3]
  localparam int unsigned TAP_T16 = 0;
  localparam int unsigned TAP_T14 = 2;
  localparam int unsigned TAP_T8  = 8;
  localparam int unsigned TAP_T3  = 13;

  localparam logic [WORD_W-1:0] SHA_K1 = 32'h5A827999;
  localparam logic [WORD_W-1:0] SHA_K2 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] SHA_K3 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] SHA_K4 = 32'hCA62C1D6;

  localparam logic [WORD_W-1:0] IV_A = 32'h67452301;
  localparam logic [WORD_W-1:0] IV_B = 32'hEFCDAB89;
  localparam logic [WORD_W-1:0] IV_C = 32'h98BADCFE;
  localparam logic [WORD_W-1:0] IV_D = 32'h10325476;
  localparam logic [WORD_W-1:0] IV_E = 32'hC3D2E1F0;

  typedef struct packed {
    logic [WORD_W-1:0] msg_word;
    logic              new_message;
  } sha1bc_in_t;

  typedef struct packed {
    logic [WORD_W-1:0]  digest_a;
    logic [WORD_W-1:0]  digest_b;
    logic [WORD_W-1:0]  digest_c;
    logic [WORD_W-1:0]  digest_d;
    logic [WORD_W-1:0]  digest_e;
    logic [COUNT_W-1:0] bytes_hashed;
  } sha1bc_out_t;

  // Classified word request handed from the front to the compression core
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              reload;
    logic              last;
  } sha1bc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sha1bc_q_stat_t;

  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;
  } sha1bc_cfg_wr_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_A = 3'd0,
    CFG_INIT_B = 3'd1,
    CFG_INIT_C = 3'd2,
    CFG_INIT_D = 3'd3,
    CFG_INIT_E = 3'd4
  } sha1bc_cfg_idx_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } sha1bc_state_t;

  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY1,
    PH_MAJORITY,
    PH_PARITY2
  } sha1bc_phase_t;

  function automatic sha1bc_phase_t round_phase(input logic [ROUND_W-1:0] r);
    sha1bc_phase_t ph;
    if (r < ROUND_W'(20))      ph = PH_CHOOSE;
    else if (r < ROUND_W'(40)) ph = PH_PARITY1;
    else if (r < ROUND_W'(60)) ph = PH_MAJORITY;
    else                       ph = PH_PARITY2;
    return ph;
  endfunction

  function automatic logic [WORD_W-1:0] round_f(input sha1bc_phase_t ph,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c,
                                                input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    unique case (ph)
      PH_CHOOSE:   f = d ^ (b & (c ^ d));
      PH_MAJORITY: f = (b & c) | (d & (b | c));
      default:     f = b ^ c ^ d;
    endcase
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] round_k(input sha1bc_phase_t ph);
    logic [WORD_W-1:0] k;
    unique case (ph)
      PH_CHOOSE:   k = SHA_K1;
      PH_PARITY1:  k = SHA_K2;
      PH_MAJORITY: k = SHA_K3;
      default:     k = SHA_K4;
    endcase
    return k;
  endfunction

  function automatic logic [WORD_W-1:0] rotl1(input logic [WORD_W-1:0] v);
    return {v[WORD_W-2:0], v[WORD_W-1]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl5(input logic [WORD_W-1:0] v);
    return {v[WORD_W-6:0], v[WORD_W-1:WORD_W-5]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl30(input logic [WORD_W-1:0] v);
    return {v[1:0], v[WORD_W-1:2]};
  endfunction

endpackage

// ===== hdl/sha1_block_compress.sv =====
// sha1_block_compress: top level of the SHA-1 block compression engine.
// Depends on sha1bc_pkg, sha1bc_front, sha1bc_fifo and sha1bc_core.
//
//  channel   ports                              moves
//  --------  ---------------------------------  ---------------------------------
//  input     in_push, in_full, in_data          one message word request
//  result    out_empty, out_pop, out_data       chaining words + byte count
//  config    cfg_we, cfg_index, cfg_wdata       init word write, no wait
//
// Flow: words are taken one a cycle into a short queue while it is not full;
// the core drains one word a cycle in its load state, then runs the rounds
// and the final add, and takes no new word until that block is done. The
// single round unit in the core limits the sustained rate.
// Reset: synchronous on rst_n, restores the standard initial values, clears
// the byte count, word position, queue and result valid flag.
// Stalls: a waiting result holds the core only at the final add; words keep
// filling the queue until it is full, which raises in_full.

module sha1_block_compress import sha1bc_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // message word requests
  input  logic                 in_push,
  output logic                 in_full,
  input  sha1bc_in_t           in_data,
  // result requests
  output logic                 out_empty,
  input  logic                 out_pop,
  output sha1bc_out_t          out_data,
  // init register writes
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  sha1bc_q_stat_t q_stat;
  sha1bc_item_t   q_in_item, q_head_item;
  logic           q_push, q_pop;
  sha1bc_cfg_wr_t cfg;

  // bundle the write port for the core
  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  // front: classify each word as message start and/or block end
  sha1bc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_item  (q_in_item)
  );

  // queue: decouple word intake from the round loop
  sha1bc_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .stat      (q_stat)
  );

  // back: gather the block, run the rounds, hold the result
  sha1bc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_item    (q_head_item),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/sha1bc_front.sv =====
// sha1bc_front: accepts message word requests, tracks the word position and
// tags each word as a message start and/or a block end. Uses sha1bc_pkg.

module sha1bc_front import sha1bc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_push,
  output logic           in_full,
  input  sha1bc_in_t     in_data,
  input  sha1bc_q_stat_t q_stat,
  output logic           q_push,
  output sha1bc_item_t   q_item
);

  logic [WORD_POS_W-1:0] pos_r, pos_nxt, pos_base;

  assign in_full = q_stat.full;
  assign q_push  = in_push && !q_stat.full;

  always_comb begin
    // a start flag drops any partial block gathered so far
    pos_base      = in_data.new_message ? '0 : pos_r;
    q_item.word   = in_data.msg_word;
    q_item.reload = in_data.new_message;
    q_item.last   = (pos_base == WORD_POS_W'(NUM_WORDS - 1));
    pos_nxt       = q_push ? pos_base + WORD_POS_W'(1) : pos_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== hdl/sha1bc_fifo.sv =====
// sha1bc_fifo: short request queue between front and compression core.
// Uses sha1bc_pkg for the request and status types.

module sha1bc_fifo import sha1bc_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sha1bc_item_t   push_item,
  input  logic           pop,
  output sha1bc_item_t   head_item,
  output sha1bc_q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sha1bc_item_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/sha1bc_core.sv =====
// sha1bc_core: schedule window, one-round-per-cycle compression, chaining
// words, byte count, init registers and the result register. Uses sha1bc_pkg.

module sha1bc_core import sha1bc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  sha1bc_cfg_wr_t cfg,
  input  sha1bc_item_t   q_item,
  input  sha1bc_q_stat_t q_stat,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output sha1bc_out_t    out_data
);

  sha1bc_state_t      state_r, state_nxt;
  logic [WORD_W-1:0]  init_r  [NUM_CHAIN];
  logic [WORD_W-1:0]  chain_r [NUM_CHAIN];
  logic [WORD_W-1:0]  var_r   [NUM_CHAIN];
  logic [WORD_W-1:0]  win_r   [NUM_WORDS];
  logic [COUNT_W-1:0] count_r, count_sum;
  logic [ROUND_W-1:0] round_r;
  logic               out_valid_r, out_valid_nxt;
  sha1bc_out_t        out_r;

  logic [WORD_W-1:0]  chain_base [NUM_CHAIN];
  logic [WORD_W-1:0]  sum        [NUM_CHAIN];
  logic [WORD_W-1:0]  w_new, t_val;
  sha1bc_phase_t      phase;
  logic               round_en, commit, out_free;

  assign out_free = !out_valid_r || out_pop;

  always_comb begin
    for (int i = 0; i < NUM_CHAIN; i++) begin
      chain_base[i] = q_item.reload ? init_r[i] : chain_r[i];
      sum[i]        = chain_r[i] + var_r[i];
    end
    count_sum = count_r + COUNT_W'(BLOCK_BYTES);
    phase     = round_phase(round_r);
    w_new     = rotl1(win_r[TAP_T16] ^ win_r[TAP_T14] ^ win_r[TAP_T8] ^ win_r[TAP_T3]);
    t_val     = rotl5(var_r[0]) + round_f(phase, var_r[1], var_r[2], var_r[3])
              + var_r[4] + round_k(phase) + win_r[TAP_T16];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (!q_stat.empty && q_item.last) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (round_r == ROUND_W'(NUM_ROUNDS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    round_en = 1'b0;
    commit   = 1'b0;
    unique case (state_r)
      ST_LOAD:  q_pop    = !q_stat.empty;
      ST_ROUND: round_en = 1'b1;
      ST_DONE:  commit   = out_free;
      default: ;
    endcase
  end

  assign out_valid_nxt = commit ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      round_r     <= '0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      init_r[0]   <= IV_A;
      init_r[1]   <= IV_B;
      init_r[2]   <= IV_C;
      init_r[3]   <= IV_D;
      init_r[4]   <= IV_E;
      chain_r[0]  <= IV_A;
      chain_r[1]  <= IV_B;
      chain_r[2]  <= IV_C;
      chain_r[3]  <= IV_D;
      chain_r[4]  <= IV_E;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg.we) begin
        unique case (cfg.index)
          CFG_INIT_A: init_r[0] <= cfg.data;
          CFG_INIT_B: init_r[1] <= cfg.data;
          CFG_INIT_C: init_r[2] <= cfg.data;
          CFG_INIT_D: init_r[3] <= cfg.data;
          CFG_INIT_E: init_r[4] <= cfg.data;
          default: ;
        endcase
      end
      if (q_pop && q_item.last) begin
        round_r <= '0;
      end else if (round_en) begin
        round_r <= round_r + ROUND_W'(1);
      end
      if (q_pop && q_item.reload) begin
        for (int i = 0; i < NUM_CHAIN; i++) chain_r[i] <= init_r[i];
        count_r <= '0;
      end else if (commit) begin
        for (int i = 0; i < NUM_CHAIN; i++) chain_r[i] <= sum[i];
        count_r <= count_sum;
      end
    end
  end

  // payload: schedule window, working variables, result register
  always_ff @(posedge clk) begin
    if (q_pop) begin
      for (int j = 0; j < NUM_WORDS - 1; j++) win_r[j] <= win_r[j+1];
      win_r[NUM_WORDS-1] <= q_item.word;
    end else if (round_en) begin
      for (int j = 0; j < NUM_WORDS - 1; j++) win_r[j] <= win_r[j+1];
      win_r[NUM_WORDS-1] <= w_new;
    end
    if (q_pop && q_item.last) begin
      for (int i = 0; i < NUM_CHAIN; i++) var_r[i] <= chain_base[i];
    end else if (round_en) begin
      var_r[0] <= t_val;
      var_r[1] <= var_r[0];
      var_r[2] <= rotl30(var_r[1]);
      var_r[3] <= var_r[2];
      var_r[4] <= var_r[3];
    end
    if (commit) begin
      out_r.digest_a     <= sum[0];
      out_r.digest_b     <= sum[1];
      out_r.digest_c     <= sum[2];
      out_r.digest_d     <= sum[3];
      out_r.digest_e     <= sum[4];
      out_r.bytes_hashed <= count_sum;
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hdl/sha1bc_checker.sv =====
// sha1bc_checker: port-level assertions for sha1_block_compress, attached by
// the bind below. Uses sha1bc_pkg for the result type.

module sha1bc_checker import sha1bc_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input sha1bc_out_t out_data
);

  // a result waiting and not taken holds its value
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed or vanished while waiting");

  // byte count always advances in whole blocks
  a_count_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.bytes_hashed[5:0] == 6'd0))
    else $error("byte count not a multiple of the block size");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown straight after reset");

  a_reset_not_full: assert property (@(posedge clk)
    !rst_n |=> !in_full)
    else $error("input full straight after reset");

endmodule

bind sha1_block_compress sha1bc_checker u_sha1bc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for sha1_block_compress; a directed table, then random
// messages under changing init words and flow control. Needs sha1bc_pkg and the hdl/ RTL.
module tb_top;
  import sha1bc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE       = 250;    // one block in the core plus the queue
  localparam int unsigned DRAIN        = 250;
  localparam int unsigned PHASE_REQS   = 180;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned HOLD_CYCLES  = 800;
  localparam int unsigned HOLD_FIRST   = 4;
  localparam int unsigned HOLD_SECOND  = 50;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned DIR_ROWS     = 7;

  // Indexes past the last init word: writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

  logic clk;
  logic rst_n = 1'b0;

  logic                 in_push   = 1'b0;
  logic                 in_full;
  sha1bc_in_t           in_data   = '0;
  logic                 out_empty;
  logic                 out_pop   = 1'b0;
  sha1bc_out_t          out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_INIT_A;
  logic [WORD_W-1:0]    cfg_wdata = '0;

  sha1_block_compress dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: init registers, chaining words, byte count and the
  // 16-word schedule window, all mirrored at the block's widths.
  // ---------------------------------------------------------------------------
  logic [WORD_W-1:0]  init_word [NUM_CHAIN];
  logic [WORD_W-1:0]  chain_word [NUM_CHAIN];
  logic [WORD_W-1:0]  sched_win [NUM_WORDS];
  logic [COUNT_W-1:0] byte_total;
  logic [3:0]         word_pos;
  logic [WORD_W-1:0]  std_iv [NUM_CHAIN] = '{IV_A, IV_B, IV_C, IV_D, IV_E};

  // Digests still owed by the block, oldest first
  sha1bc_out_t pending_digests [$];

  int unsigned bad_fields   = 0;
  int unsigned digests_seen = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned tx_idle_pct  = 19;
  int unsigned rx_idle_pct  = 46;

  function automatic logic [WORD_W-1:0] rol32(input logic [WORD_W-1:0] v,
                                              input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // Run the 80 rounds over the window and fold the result into the chain
  function automatic void sha1_compress();
    logic [WORD_W-1:0] a, b, c, d, e, f, k, w, t;
    sha1bc_phase_t     ph;
    int unsigned       r;
    a = chain_word[0];
    b = chain_word[1];
    c = chain_word[2];
    d = chain_word[3];
    e = chain_word[4];
    for (r = 0; r < NUM_ROUNDS; r++) begin
      if (r < 16) begin
        w = sched_win[r % NUM_WORDS];
      end else begin
        w = rol32(sched_win[r % NUM_WORDS] ^ sched_win[(r - 14) % NUM_WORDS]
                  ^ sched_win[(r - 8) % NUM_WORDS] ^ sched_win[(r - 3) % NUM_WORDS], 1);
        sched_win[r % NUM_WORDS] = w;
      end
      if (r < 20)      ph = PH_CHOOSE;
      else if (r < 40) ph = PH_PARITY1;
      else if (r < 60) ph = PH_MAJORITY;
      else             ph = PH_PARITY2;
      case (ph)
        PH_CHOOSE: begin
          f = d ^ (b & (c ^ d));
          k = SHA_K1;
        end
        PH_PARITY1: begin
          f = b ^ c ^ d;
          k = SHA_K2;
        end
        PH_MAJORITY: begin
          f = (b & c) | (d & (b | c));
          k = SHA_K3;
        end
        default: begin
          f = b ^ c ^ d;
          k = SHA_K4;
        end
      endcase
      t = rol32(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain_word[0] += a;
    chain_word[1] += b;
    chain_word[2] += c;
    chain_word[3] += d;
    chain_word[4] += e;
    byte_total += COUNT_W'(BLOCK_BYTES);
  endfunction

  // Take one accepted word request; queue a digest when it closes a block
  function automatic void sha1_absorb_word(input sha1bc_in_t req);
    if (req.new_message) begin
      chain_word = init_word;
      byte_total = '0;
      word_pos   = '0;
    end
    sched_win[word_pos] = req.msg_word;
    word_pos = word_pos + 1'b1;
    if (word_pos == '0) begin
      sha1_compress();
      pending_digests.push_back('{digest_a: chain_word[0], digest_b: chain_word[1],
                                  digest_c: chain_word[2], digest_d: chain_word[3],
                                  digest_e: chain_word[4], bytes_hashed: byte_total});
    end
  endfunction

  function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                      input logic [COUNT_W-1:0] got);
    if (got !== want) begin
      bad_fields++;
      if (bad_fields <= REPORT_MAX)
        $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  // Compare one popped digest with the oldest one owed
  function automatic void check_digest(input sha1bc_out_t got);
    sha1bc_out_t want;
    if (pending_digests.size() == 0) begin
      bad_fields++;
      if (bad_fields <= REPORT_MAX)
        $display("%0t: unexpected digest %h", $time, got);
    end else begin
      want = pending_digests.pop_front();
      check_field("digest_a", COUNT_W'(want.digest_a), COUNT_W'(got.digest_a));
      check_field("digest_b", COUNT_W'(want.digest_b), COUNT_W'(got.digest_b));
      check_field("digest_c", COUNT_W'(want.digest_c), COUNT_W'(got.digest_c));
      check_field("digest_d", COUNT_W'(want.digest_d), COUNT_W'(got.digest_d));
      check_field("digest_e", COUNT_W'(want.digest_e), COUNT_W'(got.digest_e));
      check_field("bytes_hashed", want.bytes_hashed, got.bytes_hashed);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything is driven with NBAs straight after a rising edge and
  // handshakes are judged on the values seen at that edge.
  // ---------------------------------------------------------------------------

  // Offer one word request, idling at random first; return once it is taken
  task automatic send_word(input logic [WORD_W-1:0] w, input logic start);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{msg_word: w, new_message: start};
    do @(posedge clk); while (in_full);
    sha1_absorb_word('{msg_word: w, new_message: start});
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < NUM_CHAIN) init_word[idx] = val;
  endtask

  // Drop the input, let the block drain and settle, then rewrite the init words
  task automatic program_init_words(input int unsigned phase);
    sha1bc_cfg_idx_t   idx;
    logic [WORD_W-1:0] val;
    int unsigned       n;
    int unsigned       k;
    in_push <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    idx = CFG_INIT_A;
    for (n = 0; n < NUM_CHAIN; n++) begin
      case (phase)
        0:       val = '0;
        1:       val = '1;
        3:       val = std_iv[n];
        5:       val = n[0] ? 32'hAAAAAAAA : 32'h55555555;
        default: val = $urandom;
      endcase
      cfg_write(idx, val);
      idx = idx.next();
    end
    // Writes past the last register must leave the init words alone
    for (k = CFG_SPARE_FIRST; k <= CFG_SPARE_LAST; k++)
      cfg_write(CFG_IDX_W'(k), $urandom);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: pop at random, with two long hold-offs so that the queue in
  // front of the core fills and in_full rises while requests keep coming.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (out_pop && !out_empty) begin
        check_digest(out_data);
        digests_seen++;
        if (digests_seen == HOLD_FIRST || digests_seen == HOLD_SECOND)
          hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= ($urandom_range(99) >= rx_idle_pct);
      end
      @(posedge clk);
    end
  end

  // Watchdog: a stuck handshake ends the run here
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              start;
    int unsigned       reps;
    logic              typed;
    sha1bc_out_t       want;
  } dir_row_t;

  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    int unsigned row;
    int unsigned rep;
    int unsigned phase;
    int unsigned sent;
    int unsigned msg_left;
    int unsigned roll;
    logic        start;

    init_word  = std_iv;
    chain_word = std_iv;
    byte_total = '0;
    word_pos   = '0;
    foreach (sched_win[i]) sched_win[i] = '0;

    // Single-block "abc" message with standard padding: its digest is the
    // well-known test vector. A partial message ahead of it is thrown away by
    // the start flag; the all-ones message at the end runs on into the
    // random part, across an init-word rewrite.
    dir_tab = '{
      '{word: 32'hFFFFFFFF, start: 1'b1, reps: 1,  typed: 1'b0, want: '0},
      '{word: 32'h00000000, start: 1'b0, reps: 2,  typed: 1'b0, want: '0},
      '{word: 32'h61626380, start: 1'b1, reps: 1,  typed: 1'b0, want: '0},
      '{word: 32'h00000000, start: 1'b0, reps: 14, typed: 1'b0, want: '0},
      '{word: 32'h00000018, start: 1'b0, reps: 1,  typed: 1'b1,
        want: '{digest_a: 32'hA9993E36, digest_b: 32'h4706816A, digest_c: 32'hBA3E2571,
                digest_d: 32'h7850C26C, digest_e: 32'h9CD0D89D, bytes_hashed: 64'd64}},
      '{word: 32'hFFFFFFFF, start: 1'b1, reps: 1,  typed: 1'b0, want: '0},
      '{word: 32'hFFFFFFFF, start: 1'b0, reps: 5,  typed: 1'b0, want: '0}
    };

    // Hold reset at the start, once
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < DIR_ROWS; row++) begin
      for (rep = 0; rep < dir_tab[row].reps; rep++)
        send_word(dir_tab[row].word, dir_tab[row].start);
      // Typed-in digest stands in for the predicted one
      if (dir_tab[row].typed)
        pending_digests[pending_digests.size() - 1] = dir_tab[row].want;
    end

    // Random messages: mostly whole blocks, some cut short, a few stray words.
    // Finish the all-ones message from the table first.
    msg_left = 10;
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      program_init_words(phase);
      case (phase / 2)
        0: begin
          tx_idle_pct = 19;
          rx_idle_pct = 46;
        end
        1: begin
          tx_idle_pct = 46;
          rx_idle_pct = 19;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (sent = 0; sent < PHASE_REQS; sent++) begin
        start = 1'b0;
        if (msg_left == 0) begin
          roll = $urandom_range(99);
          if (roll < 6) begin
            // stray word with a random start flag
            start = 1'($urandom_range(1));
          end else begin
            start    = 1'b1;
            msg_left = NUM_WORDS * $urandom_range(1, 3);
            if (roll < 16) msg_left = $urandom_range(1, msg_left - 1);
            msg_left--;
          end
        end else begin
          msg_left--;
        end
        send_word(pick_word(), start);
      end
    end

    // Drain, then allow the block's latency for anything unexpected
    in_push <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (bad_fields == 0 && pending_digests.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
